>>> rtl/core/frv_pkg.sv
`default_nettype none

package frv_pkg;

    localparam int MAX_ELEMENTS = 256;
    localparam int VALUE_W      = 32;
    localparam int IDX_W        = 8;
    localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SEARCH,
        ST_FINISH
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;          // store one element (or mark overflow)
        logic search_start;  // set up the pair walk
        logic issue;         // read one pair and advance
        logic publish;       // move result to output register, reset element count and overflow flag
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic issue_done;    // no pair left to read
        logic hit;           // pair in compare stage matches
        logic cmp_pending;   // a pair is in compare stage
        logic out_full;      // output register cannot take a result now
    } t_stat;

endpackage

`default_nettype wire

>>> rtl/core/frv_ctrl.sv
`default_nettype none

module frv_ctrl
    import frv_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    input  wire        i_in_last,
    output logic       o_in_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_in_last) begin
                        o_cmd.search_start = 1'b1;
                        n_state            = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                // stop issuing at the first match; pairs come in search order
                if (i_stat.hit) begin
                    n_state = ST_FINISH;
                end else if (!i_stat.issue_done) begin
                    o_cmd.issue = 1'b1;
                end else if (!i_stat.cmp_pending) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!i_stat.out_full) begin
                    o_cmd.publish = 1'b1;
                    n_state       = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/frv_datapath.sv
`default_nettype none

module frv_datapath
    import frv_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire  t_cmd         i_cmd,
    input  wire  [VALUE_W-1:0] i_value,
    output t_stat              o_stat,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output logic               o_out_found,
    output logic [IDX_W-1:0]   o_out_index,
    output logic               o_out_overflow
);

    logic [VALUE_W-1:0] r_mem [MAX_ELEMENTS];

    logic [CNT_W-1:0]   r_count;
    logic               r_ovf;
    logic [ADDR_W-1:0]  r_a;
    logic [CNT_W-1:0]   r_b;
    logic [VALUE_W-1:0] r_rd_a;
    logic [VALUE_W-1:0] r_rd_b;
    logic               r_cmp_vld;
    logic [ADDR_W-1:0]  r_cmp_a;
    logic               r_res_found;
    logic [IDX_W-1:0]   r_res_idx;
    logic               r_out_vld;
    logic               r_out_found;
    logic [IDX_W-1:0]   r_out_idx;
    logic               r_out_ovf;

    logic               w_full;
    logic               w_hit;
    logic [CNT_W-1:0]   w_b_inc;
    logic [IDX_W-1:0]   w_idx;

    assign w_full  = (r_count == CNT_W'(MAX_ELEMENTS));
    assign w_hit   = r_cmp_vld && (r_rd_a == r_rd_b);
    assign w_b_inc = r_b + CNT_W'(1);

    generate
        if (CNT_W > IDX_W) begin : g_idx_trunc
            assign w_idx = r_cmp_a[IDX_W-1:0];
        end else begin : g_idx_ext
            assign w_idx = IDX_W'(r_cmp_a);
        end
    endgenerate

    // store: one write port for loading, two read ports for the pair walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && !w_full) begin
            r_mem[r_count[ADDR_W-1:0]] <= i_value;
        end
        r_rd_a <= r_mem[r_a];
        r_rd_b <= r_mem[r_b[ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.publish) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end else if (i_cmd.load) begin
                if (w_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_count <= r_count + CNT_W'(1);
                end
            end
            r_cmp_vld <= i_cmd.issue;
            if (i_cmd.publish) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // pair walk: a ascending, b from a+1 up to count-1
    always_ff @(posedge i_clk) begin
        if (i_cmd.search_start) begin
            r_a         <= '0;
            r_b         <= CNT_W'(1);
            r_res_found <= 1'b0;
            r_res_idx   <= '0;
        end else begin
            if (i_cmd.issue) begin
                r_cmp_a <= r_a;
                if (w_b_inc < r_count) begin
                    r_b <= w_b_inc;
                end else begin
                    r_a <= r_a + ADDR_W'(1);
                    r_b <= CNT_W'(r_a) + CNT_W'(2);
                end
            end
            if (w_hit) begin
                r_res_found <= 1'b1;
                r_res_idx   <= w_idx;
            end
        end
        if (i_cmd.publish) begin
            r_out_found <= r_res_found;
            r_out_idx   <= r_res_idx;
            r_out_ovf   <= r_ovf;
        end
    end

    assign o_stat.issue_done  = (r_b >= r_count);
    assign o_stat.hit         = w_hit;
    assign o_stat.cmp_pending = r_cmp_vld;
    assign o_stat.out_full    = r_out_vld && !i_out_ready;

    assign o_out_valid    = r_out_vld;
    assign o_out_found    = r_out_found;
    assign o_out_index    = r_out_idx;
    assign o_out_overflow = r_out_ovf;

endmodule

`default_nettype wire

>>> rtl/core/first_repeated_value_finder_top.sv
`default_nettype none

// Finds the lowest index of an array whose value occurs again later. Elements
// stream in one per cycle on the slave side while the block is loading (tlast
// marks the final one); up to MAX_ELEMENTS are stored, later ones are dropped
// and flagged as overflow. After the last element the input stalls while the
// store is walked one pair per cycle through its two read ports, in order
// (0,1),(0,2)..(n-2,n-1), stopping at the first match, so a search ends
// early when a repeat is found early. One result then goes to the output
// register and the input reopens for the next array while that result
// waits to be taken. The store needs no clearing; the element count bounds
// every read.
module first_repeated_value_finder_top
    import frv_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  wire  [VALUE_W-1:0] i_s_axis_tdata,   // [31:0] element_value
    input  wire                i_s_axis_tlast,   // is_last
    output logic               o_m_axis_tvalid,
    input  wire                i_m_axis_tready,
    output logic [IDX_W-1:0]   o_m_axis_tdata,   // [7:0] first_index
    output logic [1:0]         o_m_axis_tuser    // [0] found, [1] overflow
);

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_found;
    logic  w_ovf;

    frv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_in_last  (i_s_axis_tlast),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    frv_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_value        (i_s_axis_tdata),
        .o_stat         (w_stat),
        .o_out_valid    (o_m_axis_tvalid),
        .i_out_ready    (i_m_axis_tready),
        .o_out_found    (w_found),
        .o_out_index    (o_m_axis_tdata),
        .o_out_overflow (w_ovf)
    );

    assign o_m_axis_tuser = {w_ovf, w_found};

endmodule

`default_nettype wire

>>> rtl/core/frv_checker.sv
`default_nettype none

module frv_checker
    import frv_pkg::*;
(
    input wire               i_clk,
    input wire               i_rst_n,
    input wire               i_s_axis_tvalid,
    input wire               o_s_axis_tready,
    input wire               i_s_axis_tlast,
    input wire               o_m_axis_tvalid,
    input wire               i_m_axis_tready,
    input wire [IDX_W-1:0]   o_m_axis_tdata,
    input wire [1:0]         o_m_axis_tuser
);

    // result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> o_m_axis_tvalid)
        else $error("result dropped before it was taken");

    a_no_index_without_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser[0]) |-> (o_m_axis_tdata == '0))
        else $error("nonzero index without a repeat");

    // the search closes the input in the cycle after the last element is accepted
    a_search_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast) |=> !o_s_axis_tready)
        else $error("input reopened right after the last element");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind first_repeated_value_finder_top frv_checker u_frv_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tlast  (i_s_axis_tlast),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb;
    import frv_pkg::*;

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic               last;
        bit                 wait_for_drain;  // hold until every verdict is back
    } t_element_item;

    typedef struct {
        logic             found;
        logic [IDX_W-1:0] index;
        logic             overflow;
    } t_repeat_verdict;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic [VALUE_W-1:0] s_tdata = '0;
    logic               s_tlast = 1'b0;
    logic               m_tready = 1'b0;
    wire                s_tready;
    wire                m_tvalid;
    wire  [IDX_W-1:0]   m_tdata;
    wire  [1:0]         m_tuser;

    first_repeated_value_finder_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    t_element_item      pending_elements[$];
    t_repeat_verdict    expected_verdicts[$];
    logic [VALUE_W-1:0] array_buf[$];

    // shadow of the block's array store
    logic [VALUE_W-1:0] shadow_store [MAX_ELEMENTS];
    int                 shadow_count = 0;
    bit                 shadow_dropped = 0;

    int  mismatches = 0;
    int  verdicts_seen = 0;
    int  repeats_seen = 0;
    int  overflows_seen = 0;
    int  item_total = 0;
    int  array_total = 0;
    longint search_budget = 0;
    longint cycle_limit = 0;
    longint cycle_cnt = 0;

    int  gap_left = 0;
    int  stall_left = 0;
    bit  src_steady = 0;
    bit  sink_steady = 0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic int pick_pause();
        if ($urandom_range(0, 99) < 80)
            return $urandom_range(0, 3);
        return $urandom_range(4, 40);
    endfunction

    task automatic flag_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    // Store one element as the block would, and on the last one search the
    // stored part for the lowest index that repeats later.
    task automatic absorb_element(input logic [VALUE_W-1:0] value, input logic last);
        t_repeat_verdict vd;
        int              a;
        int              b;
        bit              hit;
        if (shadow_count < MAX_ELEMENTS) begin
            shadow_store[shadow_count] = value;
            shadow_count++;
        end else begin
            shadow_dropped = 1;
        end
        if (last) begin
            hit = 0;
            vd.index = '0;
            for (a = 0; a < shadow_count && !hit; a++) begin
                for (b = a + 1; b < shadow_count && !hit; b++) begin
                    if (shadow_store[a] == shadow_store[b]) begin
                        hit = 1;
                        vd.index = a[IDX_W-1:0];
                    end
                end
            end
            vd.found = hit;
            vd.overflow = shadow_dropped;
            expected_verdicts.push_back(vd);
            shadow_count = 0;
            shadow_dropped = 0;
        end
    endtask

    task automatic check_verdict();
        t_repeat_verdict vd;
        verdicts_seen++;
        if (m_tuser[0] === 1'b1)
            repeats_seen++;
        if (m_tuser[1] === 1'b1)
            overflows_seen++;
        if (expected_verdicts.size() == 0) begin
            flag_mismatch($sformatf("unexpected result found=%b index=%0d overflow=%b",
                                    m_tuser[0], m_tdata, m_tuser[1]));
        end else begin
            vd = expected_verdicts.pop_front();
            if (m_tuser[0] !== vd.found)
                flag_mismatch($sformatf("result %0d: found %b, want %b",
                                        verdicts_seen, m_tuser[0], vd.found));
            if (m_tdata !== vd.index)
                flag_mismatch($sformatf("result %0d: index %0d, want %0d",
                                        verdicts_seen, m_tdata, vd.index));
            if (m_tuser[1] !== vd.overflow)
                flag_mismatch($sformatf("result %0d: overflow %b, want %b",
                                        verdicts_seen, m_tuser[1], vd.overflow));
        end
    endtask

    // move array_buf into the send queue and add its worst search time
    task automatic queue_array(input bit drain_first);
        t_element_item it;
        int            i;
        longint        n;
        for (i = 0; i < array_buf.size(); i++) begin
            it.value = array_buf[i];
            it.last = (i == array_buf.size() - 1);
            it.wait_for_drain = drain_first && (i == 0);
            pending_elements.push_back(it);
        end
        n = (array_buf.size() > MAX_ELEMENTS) ? MAX_ELEMENTS : array_buf.size();
        search_budget += n * (n - 1) / 2 + 3;
        item_total += array_buf.size();
        array_total++;
        array_buf.delete();
    endtask

    task automatic build_random_array();
        logic [VALUE_W-1:0] pool [4];
        logic [VALUE_W-1:0] base;
        int                 len;
        int                 kind;
        int                 r;
        int                 i;
        int                 j;
        r = $urandom_range(0, 9);
        if (r < 7)
            len = $urandom_range(1, 8);
        else if (r < 9)
            len = $urandom_range(9, 20);
        else
            len = $urandom_range(21, 48);
        kind = $urandom_range(0, 3);
        for (i = 0; i < 4; i++)
            pool[i] = $urandom();
        base = $urandom();
        for (i = 0; i < len; i++) begin
            case (kind)
                0, 2: array_buf.push_back($urandom());
                1: array_buf.push_back(pool[$urandom_range(0, 3)]);
                default: array_buf.push_back(base ^ (32'h1 << $urandom_range(0, 31)));
            endcase
        end
        // plant a repeat at a random pair
        if (kind >= 2 && len > 1 && $urandom_range(0, 1) == 1) begin
            i = $urandom_range(0, len - 2);
            j = $urandom_range(i + 1, len - 1);
            array_buf[j] = array_buf[i];
        end
    endtask

    task automatic build_stimulus();
        logic [23:0] hi;
        int          i;
        // single extreme element, no repeat possible
        array_buf = '{32'h8000_0000};
        queue_array(0);
        array_buf = '{32'h7FFF_FFFF, 32'h7FFF_FFFF};
        queue_array(0);
        array_buf = '{32'h0, 32'hFFFF_FFFF, 32'h5, 32'hFFFF_FFFF};
        queue_array(0);
        // the lowest first index wins, not the earliest closing pair
        array_buf = '{32'h7, 32'h3, 32'h3, 32'h7};
        queue_array(0);
        // values differing only in the sign bit are distinct
        array_buf = '{32'h8000_0001, 32'h0000_0001, 32'h8000_0000, 32'h0};
        queue_array(0);
        array_buf = '{32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'hFFFF_FFFF, 32'h0, 32'h5A5A_5A5A};
        queue_array(0);

        // full store, repeat between first and last entry; drain before it
        hi = 24'($urandom());
        for (i = 0; i < MAX_ELEMENTS; i++)
            array_buf.push_back({hi, i[7:0]});
        array_buf[MAX_ELEMENTS-1] = array_buf[0];
        queue_array(1);

        // overflow: stored part unique, dropped elements (last too) match it
        hi = 24'($urandom());
        for (i = 0; i < MAX_ELEMENTS; i++)
            array_buf.push_back({hi, i[7:0]});
        array_buf.push_back(array_buf[3]);
        array_buf.push_back(array_buf[9]);
        queue_array(0);

        while (item_total < 700 || array_total < 25) begin
            build_random_array();
            queue_array($urandom_range(0, 19) == 0);
        end

        cycle_limit = 4 * (search_budget + 42 * item_total + 42 * array_total) + 5000;
    endtask

    // element source
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                absorb_element(s_tdata, s_tlast);
                void'(pending_elements.pop_front());
                if (s_tlast)
                    src_steady = ($urandom_range(0, 3) == 0);
                if (src_steady || $urandom_range(0, 99) < 55)
                    gap_left = 0;
                else
                    gap_left = pick_pause() + 1;
            end
            if (s_tvalid && !s_tready) begin
                // hold the offered item
            end else if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_elements.size() != 0 &&
                         !(pending_elements[0].wait_for_drain &&
                           expected_verdicts.size() != 0)) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_elements[0].value;
                s_tlast  <= pending_elements[0].last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result sink
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                check_verdict();
                sink_steady = ($urandom_range(0, 4) == 0);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (sink_steady || $urandom_range(0, 99) < 75) begin
                m_tready <= 1'b1;
            end else begin
                stall_left = pick_pause();
                m_tready <= 1'b0;
            end
        end
    end

    initial begin
        @(posedge i_clk);
        while (cycle_cnt < cycle_limit) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("Timeout after %0d cycles", cycle_cnt);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        build_stimulus();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_elements.size() != 0 || s_tvalid)
            @(posedge i_clk);
        while (expected_verdicts.size() != 0)
            @(posedge i_clk);
        // catch any stray result from a late search
        repeat (200) @(posedge i_clk);
        $display("Sent %0d arrays in %0d elements, incl. a full store and an overflow.",
                 array_total, item_total);
        $display("Checked %0d results: %0d with a repeat, %0d with dropped elements.",
                 verdicts_seen, repeats_seen, overflows_seen);
        if (mismatches == 0 && expected_verdicts.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
